[hdl/cit_pkg.sv]
// ----------------------------------------------------------------------------
// Circumsphere inclusion test package
// Shared constants of the pipelined in-circumsphere predicate: default
// coordinate width, payload layout, pipeline depth and stage positions.
// ----------------------------------------------------------------------------
package cit_pkg;

   // Default coordinate width of every input field.
   localparam int COORD_WIDTH_DEF = 16;

   // Twelve coordinates per item: vertex a, vertex b, vertex c, query point.
   localparam int NUM_FIELDS = 12;
   localparam int FLD_A      = 0;
   localparam int FLD_B      = 3;
   localparam int FLD_C      = 6;
   localparam int FLD_Q      = 9;

   // The result byte carries the single flag in its lowest bit.
   localparam int RSP_TDATA_W = 8;

   // Operand slice width used by the sliced multipliers.
   localparam int MUL_SLICE_W = 24;

   // Pipeline stages, in order from input to output register.
   localparam int ST_DIFF    = 0;
   localparam int ST_PROD    = 1;
   localparam int ST_CROSS   = 2;
   localparam int ST_MUL_PP  = 3;
   localparam int ST_MUL_SUM = 4;
   localparam int ST_NSUM    = 5;
   localparam int ST_DN_PP   = 6;
   localparam int ST_DN_SUM  = 7;
   localparam int ST_RHS     = 8;
   localparam int ST_OUT     = 9;
   localparam int PIPE_DEPTH = 10;

endpackage

[hdl/cit_mul.sv]
// ----------------------------------------------------------------------------
// Sliced two-stage signed multiplier
// Splits operand b into slices, forms the partial products in the first
// register stage and adds them, shifted, in the second register stage.
// ----------------------------------------------------------------------------
module cit_mul #(
   parameter int A_W     = 8,
   parameter int B_W     = 8,
   parameter int SLICE_W = 8
) (
   input  logic                     clock,
   input  logic                     pp_en,
   input  logic                     sum_en,
   input  logic signed [A_W-1:0]    a,
   input  logic signed [B_W-1:0]    b,
   output logic signed [A_W+B_W-1:0] p
);

   localparam int NS    = (B_W + SLICE_W - 1) / SLICE_W;
   localparam int BX    = NS * SLICE_W;
   localparam int PW    = A_W + SLICE_W + 1;
   localparam int ACC_W = A_W + BX;
   localparam int OW    = A_W + B_W;

   logic signed [BX-1:0]    b_ext;
   logic signed [SLICE_W:0] slice_s [NS];
   logic signed [PW-1:0]    pp_in   [NS];
   logic signed [PW-1:0]    pp_ff   [NS];
   logic signed [ACC_W-1:0] acc;
   logic signed [OW-1:0]    p_in;
   logic signed [OW-1:0]    p_ff;

   assign b_ext = BX'(b);

   // Lower slices are unsigned digits; only the top slice carries the sign.
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         if (k == NS - 1) begin
            slice_s[k] = {b_ext[k*SLICE_W+SLICE_W-1], b_ext[k*SLICE_W +: SLICE_W]};
         end else begin
            slice_s[k] = {1'b0, b_ext[k*SLICE_W +: SLICE_W]};
         end
         pp_in[k] = PW'(a) * PW'(slice_s[k]);
      end
   end

   always_comb begin
      acc = '0;
      for (int k = 0; k < NS; k++) begin
         acc = acc + (ACC_W'(pp_ff[k]) <<< (k * SLICE_W));
      end
      p_in = OW'(acc);
   end

   always_ff @(posedge clock) begin
      if (pp_en) begin
         pp_ff <= pp_in;
      end
      if (sum_en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

[hdl/cit_front.sv]
// ----------------------------------------------------------------------------
// Circumsphere test front end
// Edge differences, squared lengths, the triangle normal w and the cross
// products v x w and w x u, together with delta = |w|^2, in three stages.
// ----------------------------------------------------------------------------
module cit_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                          clock,
   input  logic [cit_pkg::PIPE_DEPTH-1:0]                pipe_en,
   input  logic [cit_pkg::NUM_FIELDS*COORD_WIDTH-1:0]    coords,
   output logic        [2*COORD_WIDTH+1:0]               uu,
   output logic        [2*COORD_WIDTH+1:0]               vv,
   output logic        [2*COORD_WIDTH+1:0]               dd,
   output logic        [4*COORD_WIDTH+3:0]               delta,
   output logic signed [COORD_WIDTH:0]                   d    [3],
   output logic signed [3*COORD_WIDTH+2:0]               vw   [3],
   output logic signed [3*COORD_WIDTH+2:0]               wu   [3]
);
   import cit_pkg::*;

   localparam int C    = COORD_WIDTH;
   localparam int DW   = C + 1;
   localparam int SQW  = 2 * C + 2;
   localparam int WW   = 2 * C + 2;
   localparam int XW   = 3 * C + 3;
   localparam int DELW = 4 * C + 4;

   // Stage one: differences from vertex a.
   logic signed [DW-1:0]   u1_in [3], v1_in [3], d1_in [3];
   logic signed [DW-1:0]   u1_ff [3], v1_ff [3], d1_ff [3];
   // Stage two: squared lengths and the normal.
   logic signed [2*DW-1:0] usq [3], vsq [3], dsq [3];
   logic        [SQW-1:0]  uu2_in, vv2_in, dd2_in;
   logic        [SQW-1:0]  uu2_ff, vv2_ff, dd2_ff;
   logic signed [WW-1:0]   w2_in [3];
   logic signed [WW-1:0]   w2_ff [3];
   logic signed [DW-1:0]   u2_ff [3], v2_ff [3], d2_ff [3];
   // Stage three: second-level cross products and delta.
   logic signed [2*WW-1:0] wsq [3];
   logic        [DELW-1:0] delta3_in, delta3_ff;
   logic signed [XW-1:0]   vw3_in [3], wu3_in [3];
   logic signed [XW-1:0]   vw3_ff [3], wu3_ff [3];
   logic        [SQW-1:0]  uu3_ff, vv3_ff, dd3_ff;
   logic signed [DW-1:0]   d3_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u1_in[i] = DW'(coords[(FLD_B+i)*C +: C]) - DW'(coords[(FLD_A+i)*C +: C]);
         v1_in[i] = DW'(coords[(FLD_C+i)*C +: C]) - DW'(coords[(FLD_A+i)*C +: C]);
         d1_in[i] = DW'(coords[(FLD_Q+i)*C +: C]) - DW'(coords[(FLD_A+i)*C +: C]);
      end
   end

   // Sums of squares are non-negative and fit SQW bits, so wrapping adds are exact.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         usq[i] = (2*DW)'(u1_ff[i]) * (2*DW)'(u1_ff[i]);
         vsq[i] = (2*DW)'(v1_ff[i]) * (2*DW)'(v1_ff[i]);
         dsq[i] = (2*DW)'(d1_ff[i]) * (2*DW)'(d1_ff[i]);
      end
      uu2_in = SQW'(usq[0]) + SQW'(usq[1]) + SQW'(usq[2]);
      vv2_in = SQW'(vsq[0]) + SQW'(vsq[1]) + SQW'(vsq[2]);
      dd2_in = SQW'(dsq[0]) + SQW'(dsq[1]) + SQW'(dsq[2]);
      w2_in[0] = WW'(u1_ff[1]) * WW'(v1_ff[2]) - WW'(u1_ff[2]) * WW'(v1_ff[1]);
      w2_in[1] = WW'(u1_ff[2]) * WW'(v1_ff[0]) - WW'(u1_ff[0]) * WW'(v1_ff[2]);
      w2_in[2] = WW'(u1_ff[0]) * WW'(v1_ff[1]) - WW'(u1_ff[1]) * WW'(v1_ff[0]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wsq[i] = (2*WW)'(w2_ff[i]) * (2*WW)'(w2_ff[i]);
      end
      delta3_in = DELW'(wsq[0]) + DELW'(wsq[1]) + DELW'(wsq[2]);
      vw3_in[0] = XW'(v2_ff[1]) * XW'(w2_ff[2]) - XW'(v2_ff[2]) * XW'(w2_ff[1]);
      vw3_in[1] = XW'(v2_ff[2]) * XW'(w2_ff[0]) - XW'(v2_ff[0]) * XW'(w2_ff[2]);
      vw3_in[2] = XW'(v2_ff[0]) * XW'(w2_ff[1]) - XW'(v2_ff[1]) * XW'(w2_ff[0]);
      wu3_in[0] = XW'(w2_ff[1]) * XW'(u2_ff[2]) - XW'(w2_ff[2]) * XW'(u2_ff[1]);
      wu3_in[1] = XW'(w2_ff[2]) * XW'(u2_ff[0]) - XW'(w2_ff[0]) * XW'(u2_ff[2]);
      wu3_in[2] = XW'(w2_ff[0]) * XW'(u2_ff[1]) - XW'(w2_ff[1]) * XW'(u2_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (pipe_en[ST_DIFF]) begin
         u1_ff <= u1_in;
         v1_ff <= v1_in;
         d1_ff <= d1_in;
      end
      if (pipe_en[ST_PROD]) begin
         uu2_ff <= uu2_in;
         vv2_ff <= vv2_in;
         dd2_ff <= dd2_in;
         w2_ff  <= w2_in;
         u2_ff  <= u1_ff;
         v2_ff  <= v1_ff;
         d2_ff  <= d1_ff;
      end
      if (pipe_en[ST_CROSS]) begin
         delta3_ff <= delta3_in;
         vw3_ff    <= vw3_in;
         wu3_ff    <= wu3_in;
         uu3_ff    <= uu2_ff;
         vv3_ff    <= vv2_ff;
         dd3_ff    <= dd2_ff;
         d3_ff     <= d2_ff;
      end
   end

   assign uu    = uu3_ff;
   assign vv    = vv3_ff;
   assign dd    = dd3_ff;
   assign delta = delta3_ff;
   assign d     = d3_ff;
   assign vw    = vw3_ff;
   assign wu    = wu3_ff;

endmodule

[hdl/cit_back.sv]
// ----------------------------------------------------------------------------
// Circumsphere test back end
// Forms N = |u|^2 (v x w) + |v|^2 (w x u), the two sides delta*|z-a|^2 and
// (z-a).N of the final comparison, using sliced multipliers.
// ----------------------------------------------------------------------------
module cit_back #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                               clock,
   input  logic [cit_pkg::PIPE_DEPTH-1:0]     pipe_en,
   input  logic        [2*COORD_WIDTH+1:0]    uu,
   input  logic        [2*COORD_WIDTH+1:0]    vv,
   input  logic        [2*COORD_WIDTH+1:0]    dd,
   input  logic        [4*COORD_WIDTH+3:0]    delta,
   input  logic signed [COORD_WIDTH:0]        d    [3],
   input  logic signed [3*COORD_WIDTH+2:0]    vw   [3],
   input  logic signed [3*COORD_WIDTH+2:0]    wu   [3],
   output logic signed [6*COORD_WIDTH+7:0]    lhs,
   output logic signed [6*COORD_WIDTH+7:0]    rhs
);
   import cit_pkg::*;

   localparam int C    = COORD_WIDTH;
   localparam int DW   = C + 1;
   localparam int SQW  = 2 * C + 2;
   localparam int XW   = 3 * C + 3;
   localparam int DELW = 4 * C + 4;
   localparam int NW   = 5 * C + 6;
   localparam int DNW  = 6 * C + 7;
   localparam int RW   = 6 * C + 8;

   logic signed [SQW:0]   uu_s, vv_s, dd_s;
   logic signed [DELW:0]  delta_s;
   logic signed [NW-1:0]  p_uv [3], p_vv [3];
   logic signed [RW-1:0]  p_lhs;
   logic signed [DW-1:0]  d4_ff [3], d5_ff [3], d6_ff [3];
   logic signed [NW-1:0]  n6_in [3];
   logic signed [NW-1:0]  n6_ff [3];
   logic signed [RW-1:0]  lhs6_ff, lhs7_ff, lhs8_ff, lhs9_ff;
   logic signed [DNW-1:0] p_dn [3];
   logic signed [RW-1:0]  rhs9_in, rhs9_ff;

   // Unsigned magnitudes get a zero sign bit before entering the signed multipliers.
   assign uu_s    = {1'b0, uu};
   assign vv_s    = {1'b0, vv};
   assign dd_s    = {1'b0, dd};
   assign delta_s = {1'b0, delta};

   for (genvar i = 0; i < 3; i++) begin : g_n
      cit_mul #(.A_W(SQW + 1), .B_W(XW), .SLICE_W(MUL_SLICE_W)) u_mul_uv (
         .clock  (clock),
         .pp_en  (pipe_en[ST_MUL_PP]),
         .sum_en (pipe_en[ST_MUL_SUM]),
         .a      (uu_s),
         .b      (vw[i]),
         .p      (p_uv[i])
      );
      cit_mul #(.A_W(SQW + 1), .B_W(XW), .SLICE_W(MUL_SLICE_W)) u_mul_vv (
         .clock  (clock),
         .pp_en  (pipe_en[ST_MUL_PP]),
         .sum_en (pipe_en[ST_MUL_SUM]),
         .a      (vv_s),
         .b      (wu[i]),
         .p      (p_vv[i])
      );
      cit_mul #(.A_W(DW), .B_W(NW), .SLICE_W(MUL_SLICE_W)) u_mul_dn (
         .clock  (clock),
         .pp_en  (pipe_en[ST_DN_PP]),
         .sum_en (pipe_en[ST_DN_SUM]),
         .a      (d6_ff[i]),
         .b      (n6_ff[i]),
         .p      (p_dn[i])
      );
   end

   cit_mul #(.A_W(SQW + 1), .B_W(DELW + 1), .SLICE_W(MUL_SLICE_W)) u_mul_lhs (
      .clock  (clock),
      .pp_en  (pipe_en[ST_MUL_PP]),
      .sum_en (pipe_en[ST_MUL_SUM]),
      .a      (dd_s),
      .b      (delta_s),
      .p      (p_lhs)
   );

   // Both products stay below 2^(5C+4) in magnitude, so the sum fits NW bits.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n6_in[i] = p_uv[i] + p_vv[i];
      end
      rhs9_in = RW'(p_dn[0]) + RW'(p_dn[1]) + RW'(p_dn[2]);
   end

   always_ff @(posedge clock) begin
      if (pipe_en[ST_MUL_PP]) begin
         d4_ff <= d;
      end
      if (pipe_en[ST_MUL_SUM]) begin
         d5_ff <= d4_ff;
      end
      if (pipe_en[ST_NSUM]) begin
         n6_ff   <= n6_in;
         d6_ff   <= d5_ff;
         lhs6_ff <= p_lhs;
      end
      if (pipe_en[ST_DN_PP]) begin
         lhs7_ff <= lhs6_ff;
      end
      if (pipe_en[ST_DN_SUM]) begin
         lhs8_ff <= lhs7_ff;
      end
      if (pipe_en[ST_RHS]) begin
         rhs9_ff <= rhs9_in;
         lhs9_ff <= lhs8_ff;
      end
   end

   assign lhs = lhs9_ff;
   assign rhs = rhs9_ff;

endmodule

[hdl/circumsphere_inclusion_test.sv]
// Throughput: one item per cycle while the output is not stalled;
// a ten-register pipeline with a valid bit per stage.
// A stalled output only holds the stages behind it that are occupied; bubbles close up.
// Reset (synchronous, active high) empties every stage; results in flight are dropped.
// ----------------------------------------------------------------------------
// Circumsphere inclusion test
// Exact integer test of whether a query point lies strictly inside the ball
// circumscribed about a 3D triangle, evaluated in a deep pipeline.
// ----------------------------------------------------------------------------
module circumsphere_inclusion_test #(
   parameter int COORD_WIDTH = cit_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,

   // Input channel.
   input  logic req_tvalid,
   output logic req_tready,
   // tdata, lowest bit up: tri_a_x, tri_a_y, tri_a_z, tri_b_x, tri_b_y, tri_b_z,
   // tri_c_x, tri_c_y, tri_c_z, query_x, query_y, query_z (COORD_WIDTH bits each),
   // then zero padding to a whole byte.
   input  logic [((cit_pkg::NUM_FIELDS*COORD_WIDTH+7)/8)*8-1:0] req_tdata,

   // Result channel.
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata, lowest bit up: strictly_inside, then seven zero bits.
   output logic [cit_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import cit_pkg::*;

   localparam int C    = COORD_WIDTH;
   localparam int SQW  = 2 * C + 2;
   localparam int DELW = 4 * C + 4;
   localparam int XW   = 3 * C + 3;
   localparam int RW   = 6 * C + 8;

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic [PIPE_DEPTH-1:0] pipe_en;

   logic        [SQW-1:0]  uu, vv, dd;
   logic        [DELW-1:0] delta;
   logic signed [C:0]      d  [3];
   logic signed [XW-1:0]   vw [3];
   logic signed [XW-1:0]   wu [3];
   logic signed [RW-1:0]   lhs, rhs;

   logic inside_in, inside_ff;

   // A stage may load whenever it is empty or the stage after it moves on.
   // The output register moves on when it is empty or its transfer completes.
   always_comb begin
      pipe_en[ST_OUT] = !valid_ff[ST_OUT] || rsp_tready;
      for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
         pipe_en[k] = !valid_ff[k] || pipe_en[k+1];
      end
   end

   assign valid_in   = {valid_ff[PIPE_DEPTH-2:0], req_tvalid};
   assign req_tready = pipe_en[ST_DIFF];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (pipe_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Stages one to three: differences, squared lengths, normal, cross products.
   cit_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock   (clock),
      .pipe_en (pipe_en),
      .coords  (req_tdata[NUM_FIELDS*C-1:0]),
      .uu      (uu),
      .vv      (vv),
      .dd      (dd),
      .delta   (delta),
      .d       (d),
      .vw      (vw),
      .wu      (wu)
   );

   // Stages four to nine: N, then both sides of the final inequality.
   cit_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock   (clock),
      .pipe_en (pipe_en),
      .uu      (uu),
      .vv      (vv),
      .dd      (dd),
      .delta   (delta),
      .d       (d),
      .vw      (vw),
      .wu      (wu),
      .lhs     (lhs),
      .rhs     (rhs)
   );

   // Stage ten: strict comparison. A collinear triangle gives zero on both
   // sides and a query on the sphere gives equality, so both report outside.
   assign inside_in = lhs < rhs;

   always_ff @(posedge clock) begin
      if (pipe_en[ST_OUT]) begin
         inside_ff <= inside_in;
      end
   end

   assign rsp_tvalid = valid_ff[ST_OUT];
   assign rsp_tdata  = {{(RSP_TDATA_W-1){1'b0}}, inside_ff};

   // After reset the pipeline holds no items.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");

   // An empty first stage always takes a new transfer.
   a_bubble_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[ST_DIFF] |-> req_tready)
      else $error("input stalled although the first stage is empty");

   // A stalled output with an occupied stage behind it must freeze that stage.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_OUT] && !rsp_tready && valid_ff[ST_RHS]) |-> !pipe_en[ST_RHS])
      else $error("stage advanced into a stalled output register");

   // An occupied stage that is not allowed to move keeps its item.
   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_NSUM] && !pipe_en[ST_NSUM]) |=> valid_ff[ST_NSUM])
      else $error("item lost in a stalled stage");

endmodule
